// ===== hdl/encoder_rpm_setpoint_control_core_defines.svh =====
// Assertion macros shared by the encoder RPM setpoint control core.
`ifndef ENCODER_RPM_SETPOINT_CONTROL_CORE_DEFINES_SVH
`define ENCODER_RPM_SETPOINT_CONTROL_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ERCC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ERCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ERCC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ERCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/ercc_pkg.sv =====
// Types and constants of the encoder RPM setpoint control core.
`timescale 1ns / 1ps
package ercc_pkg;

    localparam int RPM_W  = 14;
    localparam int STEP_W = 8;
    localparam int LOCK_W = 16;
    localparam int FREQ_W = 20;
    localparam int TICK_W = 32;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_STEP   = 2'd1,
        OP_BUTTON = 2'd2,
        OP_SWITCH = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_MIN_RPM       = 3'd0,
        REG_MAX_RPM       = 3'd1,
        REG_COARSE_STEP   = 3'd2,
        REG_FINE_STEP     = 3'd3,
        REG_LOCKOUT_TICKS = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [RPM_W-1:0]  min_rpm;
        logic [RPM_W-1:0]  max_rpm;
        logic [STEP_W-1:0] coarse_step;
        logic [STEP_W-1:0] fine_step;
        logic [LOCK_W-1:0] lockout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [RPM_W-1:0]  set_rpm;
        logic [RPM_W-1:0]  running_rpm;
        logic [FREQ_W-1:0] pulse_freq_mhz;
        logic              pulses_on;
        logic              fine_mode;
        logic              rpm_match;
        logic              event_taken;
    } res_t;

endpackage

// ===== hdl/ercc_ifs.sv =====
// Event and result channel interfaces of the encoder RPM setpoint control core.
`timescale 1ns / 1ps
interface ercc_evt_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic       direction_level;

    modport source (output valid, output operation, output direction_level, input ready);
    modport sink (input valid, input operation, input direction_level, output ready);
endinterface

interface ercc_rslt_if;
    import ercc_pkg::*;
    logic              valid;
    logic              ready;
    logic [RPM_W-1:0]  set_rpm;
    logic [RPM_W-1:0]  running_rpm;
    logic [FREQ_W-1:0] pulse_freq_mhz;
    logic              pulses_on;
    logic              fine_mode;
    logic              rpm_match;
    logic              event_taken;

    modport source (output valid, output set_rpm, output running_rpm, output pulse_freq_mhz,
                    output pulses_on, output fine_mode, output rpm_match, output event_taken,
                    input ready);
    modport sink (input valid, input set_rpm, input running_rpm, input pulse_freq_mhz,
                  input pulses_on, input fine_mode, input rpm_match, input event_taken,
                  output ready);
endinterface

// ===== hdl/encoder_rpm_setpoint_control_core.sv =====
// Top level of the encoder RPM setpoint control core.
// Events (tick, encoder step, push button, switch edge) arrive on the evt
// channel; each accepted transaction yields exactly one transaction on the
// rslt channel with the commanded and running RPM, the applied pulse
// frequency in mHz, the flags and whether the event passed the lockout.
// An event is captured in an input register, the state update is one
// combinational pass from that register into the result register, which
// presents the result once the result register is free to take it.
// Throughput is one event per cycle while rslt does not stall.
// When rslt stalls, the result register holds, the input register fills, and
// evt.ready drops until rslt.ready returns.
// The APB port writes and reads the limits, steps and lockout time; the user
// must write it only while no event is in flight; this is not enforced.
// Reset loads the register defaults, clears the tick counter and lockout,
// sets both RPM values to 6900 and clears pulse enable and fine mode.
`timescale 1ns / 1ps
module encoder_rpm_setpoint_control_core (
    input  logic                        clk,
    input  logic                        rst_n,
    ercc_evt_if.sink                    evt,
    ercc_rslt_if.source                 rslt,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ercc_pkg::ADDR_W-1:0] paddr,
    input  logic [ercc_pkg::DATA_W-1:0] pwdata,
    output logic [ercc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import ercc_pkg::*;

    cfg_t       cfg;
    res_t       res;
    res_t       out_reg;
    logic       out_valid_reg, out_valid_next;
    logic       s1_valid_reg, s1_valid_next;
    logic [1:0] s1_op_reg;
    logic       s1_dir_reg;
    logic       out_free;
    logic       s1_go;
    logic       evt_take;

    ercc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ercc_update u_update (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .go              (s1_go),
        .operation       (s1_op_reg),
        .direction_level (s1_dir_reg),
        .res             (res)
    );

    assign out_free  = !out_valid_reg || rslt.ready;
    assign s1_go     = s1_valid_reg && out_free;
    assign evt.ready = !s1_valid_reg || s1_go;
    assign evt_take  = evt.valid && evt.ready;

    assign s1_valid_next  = evt_take || (s1_valid_reg && !s1_go);
    assign out_valid_next = s1_go || (out_valid_reg && !rslt.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            s1_op_reg  <= evt.operation;
            s1_dir_reg <= evt.direction_level;
        end
        if (s1_go)
            out_reg <= res;
    end

    assign rslt.valid          = out_valid_reg;
    assign rslt.set_rpm        = out_reg.set_rpm;
    assign rslt.running_rpm    = out_reg.running_rpm;
    assign rslt.pulse_freq_mhz = out_reg.pulse_freq_mhz;
    assign rslt.pulses_on      = out_reg.pulses_on;
    assign rslt.fine_mode      = out_reg.fine_mode;
    assign rslt.rpm_match      = out_reg.rpm_match;
    assign rslt.event_taken    = out_reg.event_taken;

endmodule

// ===== hdl/ercc_cfg.sv =====
// APB register file holding the limits, steps and lockout time.
`timescale 1ns / 1ps
module ercc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ercc_pkg::ADDR_W-1:0] paddr,
    input  logic [ercc_pkg::DATA_W-1:0] pwdata,
    output logic [ercc_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output ercc_pkg::cfg_t              cfg
);
    import ercc_pkg::*;

    localparam logic [RPM_W-1:0]  MIN_RPM_RST  = RPM_W'(2500);
    localparam logic [RPM_W-1:0]  MAX_RPM_RST  = RPM_W'(9000);
    localparam logic [STEP_W-1:0] COARSE_RST   = STEP_W'(10);
    localparam logic [STEP_W-1:0] FINE_RST     = STEP_W'(1);
    localparam logic [LOCK_W-1:0] LOCKOUT_RST  = LOCK_W'(15);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MIN_RPM:       cfg_next.min_rpm       = pwdata[RPM_W-1:0];
                REG_MAX_RPM:       cfg_next.max_rpm       = pwdata[RPM_W-1:0];
                REG_COARSE_STEP:   cfg_next.coarse_step   = pwdata[STEP_W-1:0];
                REG_FINE_STEP:     cfg_next.fine_step     = pwdata[STEP_W-1:0];
                REG_LOCKOUT_TICKS: cfg_next.lockout_ticks = pwdata[LOCK_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MIN_RPM:       prdata = DATA_W'(cfg_reg.min_rpm);
            REG_MAX_RPM:       prdata = DATA_W'(cfg_reg.max_rpm);
            REG_COARSE_STEP:   prdata = DATA_W'(cfg_reg.coarse_step);
            REG_FINE_STEP:     prdata = DATA_W'(cfg_reg.fine_step);
            REG_LOCKOUT_TICKS: prdata = DATA_W'(cfg_reg.lockout_ticks);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_rpm       <= MIN_RPM_RST;
            cfg_reg.max_rpm       <= MAX_RPM_RST;
            cfg_reg.coarse_step   <= COARSE_RST;
            cfg_reg.fine_step     <= FINE_RST;
            cfg_reg.lockout_ticks <= LOCKOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/ercc_update.sv =====
// Controller state and the combinational update that one event applies to it.
`timescale 1ns / 1ps
`include "encoder_rpm_setpoint_control_core_defines.svh"
module ercc_update (
    input  logic           clk,
    input  logic           rst_n,
    input  ercc_pkg::cfg_t cfg,
    input  logic           go,
    input  logic [1:0]     operation,
    input  logic           direction_level,
    output ercc_pkg::res_t res
);
    import ercc_pkg::*;

    localparam logic [RPM_W-1:0]  RPM_RST   = RPM_W'(6900);
    localparam logic [FREQ_W-1:0] FREQ_RST  = FREQ_W'(229997);
    // rpm*33333/1000 = 33*rpm + floor(333*rpm/1000); the second term is one
    // multiply by 333*ceil(2^33/1000), exact for every 14-bit rpm.
    localparam logic [31:0]       FREQ_MUL  = 32'd2860448355;
    localparam int                FREQ_SHIFT = 33;
    localparam int                PROD_W    = RPM_W + 32;

    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [TICK_W-1:0] next_allowed_reg, next_allowed_next;
    logic [RPM_W-1:0]  cmd_reg, cmd_next;
    logic [RPM_W-1:0]  applied_reg, applied_next;
    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic              enable_reg, enable_next;
    logic              fine_reg, fine_next;

    op_t               op;
    logic              taken;
    logic              apply;
    logic [STEP_W-1:0] step;
    logic [RPM_W:0]    lower_sum;
    logic [RPM_W:0]    upper_sum;
    logic [RPM_W-1:0]  stepped;
    logic [RPM_W-1:0]  clamped;
    logic [PROD_W-1:0] prod;
    logic [FREQ_W-1:0] freq_calc;

    assign op    = op_t'(operation);
    assign taken = (op != OP_TICK) && (tick_count_reg > next_allowed_reg);
    assign step  = fine_reg ? cfg.fine_step : cfg.coarse_step;

    assign lower_sum = {1'b0, cfg.min_rpm} + (RPM_W+1)'(step);
    assign upper_sum = {1'b0, cmd_reg} + (RPM_W+1)'(step);

    always_comb
    begin
        if (direction_level)
        begin
            if ({1'b0, cmd_reg} <= lower_sum)
                stepped = cfg.min_rpm;
            else
                stepped = cmd_reg - RPM_W'(step);
        end
        else
        begin
            if (upper_sum >= {1'b0, cfg.max_rpm})
                stepped = cfg.max_rpm;
            else
                stepped = upper_sum[RPM_W-1:0];
        end
    end

    always_comb
    begin
        if (cmd_reg > cfg.max_rpm)
            clamped = cfg.max_rpm;
        else if (cmd_reg < cfg.min_rpm)
            clamped = cfg.min_rpm;
        else
            clamped = cmd_reg;
    end

    assign prod      = PROD_W'(clamped) * PROD_W'(FREQ_MUL);
    assign freq_calc = (FREQ_W'(clamped) << 5) + FREQ_W'(clamped)
                     + FREQ_W'(prod[PROD_W-1:FREQ_SHIFT]);

    always_comb
    begin
        tick_count_next   = tick_count_reg;
        next_allowed_next = next_allowed_reg;
        cmd_next          = cmd_reg;
        applied_next      = applied_reg;
        freq_next         = freq_reg;
        enable_next       = enable_reg;
        fine_next         = fine_reg;
        apply             = 1'b0;

        if (taken)
            next_allowed_next = tick_count_reg + TICK_W'(cfg.lockout_ticks);

        case (op)
            OP_TICK:
            begin
                tick_count_next = tick_count_reg + TICK_W'(1);
            end
            OP_STEP:
            begin
                if (taken)
                    cmd_next = stepped;
            end
            OP_BUTTON:
            begin
                if (taken)
                begin
                    enable_next = !enable_reg;
                    apply       = 1'b1;
                end
            end
            OP_SWITCH:
            begin
                if (taken)
                begin
                    fine_next = !fine_reg;
                    apply     = fine_reg;
                end
            end
            default:
            begin
                tick_count_next = tick_count_reg;
            end
        endcase

        if (apply)
        begin
            cmd_next     = clamped;
            applied_next = clamped;
            freq_next    = freq_calc;
        end
    end

    always_comb
    begin
        res.set_rpm        = cmd_next;
        res.running_rpm    = applied_next;
        res.pulse_freq_mhz = freq_next;
        res.pulses_on      = enable_next;
        res.fine_mode      = fine_next;
        res.rpm_match      = (cmd_next == applied_next);
        res.event_taken    = taken;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            next_allowed_reg <= '0;
            cmd_reg          <= RPM_RST;
            applied_reg      <= RPM_RST;
            freq_reg         <= FREQ_RST;
            enable_reg       <= 1'b0;
            fine_reg         <= 1'b0;
        end
        else if (go)
        begin
            tick_count_reg   <= tick_count_next;
            next_allowed_reg <= next_allowed_next;
            cmd_reg          <= cmd_next;
            applied_reg      <= applied_next;
            freq_reg         <= freq_next;
            enable_reg       <= enable_next;
            fine_reg         <= fine_next;
        end
    end

    `ERCC_ASSERT_NEXT(a_reject_keeps_state, clk, rst_n, go && !taken, $stable(cmd_reg) && $stable(applied_reg) && $stable(enable_reg) && $stable(fine_reg) && $stable(next_allowed_reg))
    `ERCC_ASSERT_NEXT(a_tick_advances, clk, rst_n, go && (op == OP_TICK), tick_count_reg == $past(tick_count_reg) + TICK_W'(1))
    `ERCC_ASSERT_IMP(a_button_applies, clk, rst_n, taken && (op == OP_BUTTON), res.rpm_match && (res.pulses_on != enable_reg))

endmodule
